// File: hw/rtl/mpa_pkg.sv
// Shared constants, register codes and types for the max pooling block.
// No dependencies; mpa_front, mpa_back and the top file refer to it by scoped names.
`default_nettype none

package mpa_pkg;

  localparam int MAX_COLS     = 256;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_WINDOW   = 8;
  localparam int SAMPLE_BITS  = 16;

  localparam int ROW_LIMIT    = 4096;
  localparam int ROWS_W       = 13;
  localparam int COLS_REG_W   = 9;
  localparam int CHAN_REG_W   = 5;
  localparam int WIN_REG_W    = 4;
  localparam int ROW_POS_W    = 12;
  localparam int ARG_W        = 3;
  localparam int OUT_CH_W     = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [ROWS_W-1:0]     RESET_ROWS  = 13'd28;
  localparam logic [COLS_REG_W-1:0] RESET_COLS  = 9'd28;
  localparam logic [CHAN_REG_W-1:0] RESET_CHANS = 5'd1;
  localparam logic [WIN_REG_W-1:0]  RESET_KROWS = 4'd2;
  localparam logic [WIN_REG_W-1:0]  RESET_KCOLS = 4'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_ROWS    = 3'd0,
    REG_IMAGE_COLS    = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_WINDOW_ROWS   = 3'd3,
    REG_WINDOW_COLS   = 3'd4
  } mpa_reg_t;

  typedef struct packed {
    logic first;
    logic win_end;
    logic img_end;
  } mpa_flags_t;

  localparam int FLAGS_W = $bits(mpa_flags_t);

endpackage

`default_nettype wire

// File: hw/rtl/mpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mpa_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mpa_fifo.sv
// Short request queue between the front and back parts.
// No dependencies.
`default_nettype none

module mpa_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             pop,
  output      logic             nonempty,
  output      logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: hw/rtl/mpa_front.sv
// Front part: configuration registers, raster position counters and
// classification of each sample into a store request. Uses mpa_pkg.
`default_nettype none

module mpa_front #(
  parameter int MAX_COLS     = mpa_pkg::MAX_COLS,
  parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS,
  parameter int MAX_WINDOW   = mpa_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS  = mpa_pkg::SAMPLE_BITS,
  localparam int AW   = $clog2(MAX_COLS * MAX_CHANNELS),
  localparam int WINW = $clog2(MAX_WINDOW),
  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [mpa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mpa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample,
  input  wire logic                                queue_full,
  output      logic                                push,
  output      logic [SAMPLE_BITS-1:0]              req_sample,
  output      logic [AW-1:0]                       req_addr,
  output      logic [WINW-1:0]                     req_row,
  output      logic [WINW-1:0]                     req_col,
  output      logic [CHW-1:0]                      req_chan,
  output      mpa_pkg::mpa_flags_t                 req_flags
);

  localparam int RW   = mpa_pkg::ROWS_W;
  localparam int RPW  = mpa_pkg::ROW_POS_W;
  localparam int RSW  = RW + 1;
  localparam int COLW = $clog2(MAX_COLS);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int CSW  = CW + 2;
  localparam int CHNW = $clog2(MAX_CHANNELS + 1);
  localparam int KW   = $clog2(MAX_WINDOW + 1);

  logic [RW-1:0]                     reg_rows;
  logic [mpa_pkg::COLS_REG_W-1:0]    reg_cols;
  logic [mpa_pkg::CHAN_REG_W-1:0]    reg_chans;
  logic [mpa_pkg::WIN_REG_W-1:0]     reg_krows;
  logic [mpa_pkg::WIN_REG_W-1:0]     reg_kcols;

  logic [RW-1:0]   rows_used;
  logic [CW-1:0]   cols_used;
  logic [CHNW-1:0] chans_used;
  logic [KW-1:0]   krows_used;
  logic [KW-1:0]   kcols_used;

  logic [RPW-1:0]  row_pos;
  logic [RPW-1:0]  row_start;
  logic [WINW-1:0] row_in_win;
  logic [COLW-1:0] col_pos;
  logic [COLW-1:0] col_start;
  logic [WINW-1:0] col_in_win;
  logic [CHW-1:0]  chan_pos;
  logic [AW-1:0]   addr_base;

  logic            cfg_known;
  logic            accept;
  logic [RSW-1:0]  row_band_end;
  logic [CSW-1:0]  col_band_end;
  logic            row_ok;
  logic            col_ok;
  logic            row_last_band;
  logic            col_last_band;
  logic            chan_last;
  logic            col_last;
  logic            row_last;
  logic            col_win_last;
  logic            row_win_last;

  always_comb begin
    cfg_known = 1'b1;
    unique case (cfg_index)
      mpa_pkg::REG_IMAGE_ROWS,
      mpa_pkg::REG_IMAGE_COLS,
      mpa_pkg::REG_CHANNEL_COUNT,
      mpa_pkg::REG_WINDOW_ROWS,
      mpa_pkg::REG_WINDOW_COLS: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_rows  <= mpa_pkg::RESET_ROWS;
      reg_cols  <= mpa_pkg::RESET_COLS;
      reg_chans <= mpa_pkg::RESET_CHANS;
      reg_krows <= mpa_pkg::RESET_KROWS;
      reg_kcols <= mpa_pkg::RESET_KCOLS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpa_pkg::REG_IMAGE_ROWS:    reg_rows  <= cfg_data[RW-1:0];
        mpa_pkg::REG_IMAGE_COLS:    reg_cols  <= cfg_data[mpa_pkg::COLS_REG_W-1:0];
        mpa_pkg::REG_CHANNEL_COUNT: reg_chans <= cfg_data[mpa_pkg::CHAN_REG_W-1:0];
        mpa_pkg::REG_WINDOW_ROWS:   reg_krows <= cfg_data[mpa_pkg::WIN_REG_W-1:0];
        mpa_pkg::REG_WINDOW_COLS:   reg_kcols <= cfg_data[mpa_pkg::WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp each register into its usable range, zero counts as one
  assign rows_used  = (reg_rows == '0) ? RW'(1) :
                      (32'(reg_rows) > mpa_pkg::ROW_LIMIT) ? RW'(mpa_pkg::ROW_LIMIT) :
                      reg_rows;
  assign cols_used  = (reg_cols == '0) ? CW'(1) :
                      (32'(reg_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(reg_cols);
  assign chans_used = (reg_chans == '0) ? CHNW'(1) :
                      (32'(reg_chans) > MAX_CHANNELS) ? CHNW'(MAX_CHANNELS) :
                      CHNW'(reg_chans);
  assign krows_used = (reg_krows == '0) ? KW'(1) :
                      (32'(reg_krows) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(reg_krows);
  assign kcols_used = (reg_kcols == '0) ? KW'(1) :
                      (32'(reg_kcols) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(reg_kcols);

  // a window band is inside the pooled area when it ends at or before the edge
  assign row_band_end  = RSW'(row_start) + RSW'(krows_used);
  assign col_band_end  = CSW'(col_start) + CSW'(kcols_used);
  assign row_ok        = (row_band_end <= RSW'(rows_used));
  assign col_ok        = (col_band_end <= CSW'(cols_used));
  assign row_last_band = ((row_band_end + RSW'(krows_used)) > RSW'(rows_used));
  assign col_last_band = ((col_band_end + CSW'(kcols_used)) > CSW'(cols_used));

  assign chan_last    = ((CHNW'(chan_pos) + CHNW'(1)) == chans_used);
  assign col_last     = ((CW'(col_pos) + CW'(1)) == cols_used);
  assign row_last     = ((RW'(row_pos) + RW'(1)) == rows_used);
  assign col_win_last = ((KW'(col_in_win) + KW'(1)) == kcols_used);
  assign row_win_last = ((KW'(row_in_win) + KW'(1)) == krows_used);

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && row_ok && col_ok;

  assign req_sample        = sample;
  assign req_addr          = addr_base + AW'(chan_pos);
  assign req_row           = row_in_win;
  assign req_col           = col_in_win;
  assign req_chan          = chan_pos;
  assign req_flags.first   = (row_in_win == '0) && (col_in_win == '0);
  assign req_flags.win_end = row_win_last && col_win_last;
  assign req_flags.img_end = row_last_band && col_last_band && chan_last;

  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_known)) begin
      row_pos    <= '0;
      row_start  <= '0;
      row_in_win <= '0;
      col_pos    <= '0;
      col_start  <= '0;
      col_in_win <= '0;
      chan_pos   <= '0;
      addr_base  <= '0;
    end else if (accept) begin
      if (!chan_last) begin
        chan_pos <= chan_pos + CHW'(1);
      end else begin
        chan_pos <= '0;
        if (col_last) begin
          col_pos    <= '0;
          col_start  <= '0;
          col_in_win <= '0;
          addr_base  <= '0;
          if (row_last) begin
            row_pos    <= '0;
            row_start  <= '0;
            row_in_win <= '0;
          end else begin
            row_pos <= row_pos + RPW'(1);
            if (row_win_last) begin
              row_in_win <= '0;
              row_start  <= row_pos + RPW'(1);
            end else begin
              row_in_win <= row_in_win + WINW'(1);
            end
          end
        end else begin
          col_pos <= col_pos + COLW'(1);
          if (col_win_last) begin
            col_in_win <= '0;
            col_start  <= col_pos + COLW'(1);
            addr_base  <= addr_base + AW'(chans_used);
          end else begin
            col_in_win <= col_in_win + WINW'(1);
          end
        end
      end
    end
  end

  a_offsets_in_window: assert property (@(posedge clk) disable iff (rst)
      (KW'(row_in_win) < krows_used) && (KW'(col_in_win) < kcols_used))
    else $error("window offset beyond window size");

endmodule

`default_nettype wire

// File: hw/rtl/mpa_back.sv
// Back part: read-modify-write of the window store with bypass, and the
// result register. Uses mpa_pkg and mpa_ram.
`default_nettype none

module mpa_back #(
  parameter int MAX_COLS     = mpa_pkg::MAX_COLS,
  parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS,
  parameter int MAX_WINDOW   = mpa_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS  = mpa_pkg::SAMPLE_BITS,
  localparam int AW   = $clog2(MAX_COLS * MAX_CHANNELS),
  localparam int WINW = $clog2(MAX_WINDOW),
  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output      logic                                pop,
  input  wire logic [SAMPLE_BITS-1:0]              req_sample,
  input  wire logic [AW-1:0]                       req_addr,
  input  wire logic [WINW-1:0]                     req_row,
  input  wire logic [WINW-1:0]                     req_col,
  input  wire logic [CHW-1:0]                      req_chan,
  input  wire mpa_pkg::mpa_flags_t                 req_flags,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic signed [SAMPLE_BITS-1:0]       pooled_value,
  output      logic [mpa_pkg::ARG_W-1:0]           arg_row,
  output      logic [mpa_pkg::ARG_W-1:0]           arg_col,
  output      logic [mpa_pkg::OUT_CH_W-1:0]        out_channel,
  output      logic                                image_done
);

  localparam int EW    = SAMPLE_BITS + 2 * WINW;
  localparam int DEPTH = MAX_COLS * MAX_CHANNELS;

  logic                    s1_valid;
  logic [SAMPLE_BITS-1:0]  s1_sample;
  logic [AW-1:0]           s1_addr;
  logic [WINW-1:0]         s1_row;
  logic [WINW-1:0]         s1_col;
  logic [CHW-1:0]          s1_chan;
  mpa_pkg::mpa_flags_t     s1_flags;
  logic                    byp_hit;
  logic [EW-1:0]           byp_data;

  logic                    s1_adv;
  logic                    s1_ready;
  logic [EW-1:0]           ram_rdata;
  logic [EW-1:0]           old_entry;
  logic [EW-1:0]           new_entry;
  logic signed [SAMPLE_BITS-1:0] old_value;

  assign s1_adv   = s1_valid && (!s1_flags.win_end || !out_valid || !out_stall);
  assign s1_ready = !s1_valid || s1_adv;
  assign pop      = req_valid && s1_ready;

  mpa_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (new_entry),
    .re    (pop),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  assign old_entry = byp_hit ? byp_data : ram_rdata;
  assign old_value = $signed(old_entry[EW-1 -: SAMPLE_BITS]);

  always_comb begin
    new_entry = old_entry;
    if (s1_flags.first) begin
      new_entry = {s1_sample, {(2 * WINW){1'b0}}};
    end else if ($signed(s1_sample) > old_value) begin
      new_entry = {s1_sample, s1_row, s1_col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req_valid;
    end
  end

  // capture a write to the same entry that lands in the cycle of the read
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_sample <= req_sample;
      s1_addr   <= req_addr;
      s1_row    <= req_row;
      s1_col    <= req_col;
      s1_chan   <= req_chan;
      s1_flags  <= req_flags;
      byp_hit   <= s1_adv && (s1_addr == req_addr);
      byp_data  <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_flags.win_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.win_end) begin
      pooled_value <= $signed(new_entry[EW-1 -: SAMPLE_BITS]);
      arg_row      <= mpa_pkg::ARG_W'(new_entry[2*WINW-1 -: WINW]);
      arg_col      <= mpa_pkg::ARG_W'(new_entry[WINW-1:0]);
      out_channel  <= mpa_pkg::OUT_CH_W'(s1_chan);
      image_done   <= s1_flags.img_end;
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
      s1_adv && s1_flags.win_end |=> out_valid)
    else $error("window end did not load the result register");
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !s1_adv |=> s1_valid && $stable(s1_addr))
    else $error("stalled store request lost");

endmodule

`default_nettype wire

// File: hw/rtl/max_pool_2d_with_argmax.sv
// Non-overlapping 2-D max pooling with argmax over a raster sample stream.
// Throughput: one sample per cycle while in_stall is low; the window store does one
// read-modify-write per sample in the pooled area, with a bypass for back-to-back
// requests to the same entry. Path: request queue, store stage, result register.
// Reset: counters, queue and valid flags cleared, registers to 28/28/1/2/2;
// the window store is not cleared, every entry is loaded by a window's first sample.
`default_nettype none

module max_pool_2d_with_argmax #(
  parameter int MAX_COLS     = mpa_pkg::MAX_COLS,
  parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS,
  parameter int MAX_WINDOW   = mpa_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS  = mpa_pkg::SAMPLE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [mpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic signed [SAMPLE_BITS-1:0]   pooled_value,
  output      logic [mpa_pkg::ARG_W-1:0]       arg_row,
  output      logic [mpa_pkg::ARG_W-1:0]       arg_col,
  output      logic [mpa_pkg::OUT_CH_W-1:0]    out_channel,
  output      logic                            image_done
);

  localparam int AW   = $clog2(MAX_COLS * MAX_CHANNELS);
  localparam int WINW = $clog2(MAX_WINDOW);
  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int QW   = SAMPLE_BITS + AW + 2 * WINW + CHW + mpa_pkg::FLAGS_W;

  logic                   push;
  logic                   queue_full;
  logic                   queue_nonempty;
  logic                   pop;
  logic [QW-1:0]          queue_wdata;
  logic [QW-1:0]          queue_rdata;

  logic [SAMPLE_BITS-1:0] f_sample;
  logic [AW-1:0]          f_addr;
  logic [WINW-1:0]        f_row;
  logic [WINW-1:0]        f_col;
  logic [CHW-1:0]         f_chan;
  mpa_pkg::mpa_flags_t    f_flags;

  logic [SAMPLE_BITS-1:0] b_sample;
  logic [AW-1:0]          b_addr;
  logic [WINW-1:0]        b_row;
  logic [WINW-1:0]        b_col;
  logic [CHW-1:0]         b_chan;
  mpa_pkg::mpa_flags_t    b_flags;

  assign cfg_ready = 1'b1;

  mpa_front #(
    .MAX_COLS     (MAX_COLS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .queue_full (queue_full),
    .push       (push),
    .req_sample (f_sample),
    .req_addr   (f_addr),
    .req_row    (f_row),
    .req_col    (f_col),
    .req_chan   (f_chan),
    .req_flags  (f_flags)
  );

  assign queue_wdata = {f_sample, f_addr, f_row, f_col, f_chan, f_flags};

  mpa_fifo #(
    .WIDTH (QW),
    .DEPTH (mpa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (queue_wdata),
    .full     (queue_full),
    .pop      (pop),
    .nonempty (queue_nonempty),
    .rdata    (queue_rdata)
  );

  assign {b_sample, b_addr, b_row, b_col, b_chan, b_flags} = queue_rdata;

  mpa_back #(
    .MAX_COLS     (MAX_COLS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (queue_nonempty),
    .pop          (pop),
    .req_sample   (b_sample),
    .req_addr     (b_addr),
    .req_row      (b_row),
    .req_col      (b_col),
    .req_chan     (b_chan),
    .req_flags    (b_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pooled_value (pooled_value),
    .arg_row      (arg_row),
    .arg_col      (arg_col),
    .out_channel  (out_channel),
    .image_done   (image_done)
  );

endmodule

`default_nettype wire
